// ===== design/lru_stack_page_replacement_core_assert.svh =====
// ----------------------------------------------------------------------------
// LRU stack assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LRU_STACK_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define LRU_STACK_PAGE_REPLACEMENT_CORE_ASSERT_SVH

`ifndef SYNTH
// Checked only outside reset
`define LRUS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lru stack assertion failed");
// Checked on every edge, reset included
`define LRUS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lru stack assertion failed");
`else
`define LRUS_ASSERT(lbl, clk, rst_n, prop)
`define LRUS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== design/lrus_pkg.sv =====
// ----------------------------------------------------------------------------
// lrus_pkg
// Shared types and constants of the LRU stack page replacement core.
// ----------------------------------------------------------------------------
package lrus_pkg;

    // Frame limit register
    localparam int unsigned CFG_W = 5;
    localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd4;

    // Replacement counter
    localparam int unsigned COUNT_W = 32;

    // Per-item control broadcast to every cell
    typedef struct packed {
        logic load;      // item accepted this cycle
        logic hit_mode;  // shift above the hit, else shift up to the bound
    } t_cell_ctrl;

endpackage

// ===== design/lrus_if.sv =====
// ----------------------------------------------------------------------------
// lrus_if
// Valid/ready channels for page references and replacement results.
// ----------------------------------------------------------------------------
interface lrus_ref_if #(
    parameter int unsigned PAGE_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;
    logic                 last_ref;

    modport source (output valid, output page, output last_ref, input ready);
    modport sink   (input valid, input page, input last_ref, output ready);
endinterface

interface lrus_res_if #(
    parameter int unsigned PAGE_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [31:0]          replacements;
    logic                 trace_done;

    modport source (output valid, output hit, output evicted_valid,
                    output evicted_page, output replacements,
                    output trace_done, input ready);
    modport sink   (input valid, input hit, input evicted_valid,
                    input evicted_page, input replacements,
                    input trace_done, output ready);
endinterface

// ===== design/lrus_cell.sv =====
// ----------------------------------------------------------------------------
// lrus_cell
// One stack slot: holds a page, compares it with the reference and takes
// the page of the slot above when the stack shifts down.
// ----------------------------------------------------------------------------
module lrus_cell #(
    parameter int unsigned IDX       = 0,
    parameter int unsigned PAGE_BITS = 16,
    parameter int unsigned OCC_W     = 5,
    parameter int unsigned IDX_W     = 4
) (
    input  logic                  i_clk,
    input  lrus_pkg::t_cell_ctrl  i_ctrl,
    input  logic [PAGE_BITS-1:0]  i_query,
    input  logic [PAGE_BITS-1:0]  i_prev_page,
    input  logic [IDX_W-1:0]      i_bound,
    input  logic [OCC_W-1:0]      i_occ,
    input  logic                  i_match_below,
    output logic                  o_match_below,
    output logic [PAGE_BITS-1:0]  o_page
);
    import lrus_pkg::*;

    localparam logic [OCC_W-1:0] IDX_OCC = OCC_W'(IDX);
    localparam logic [IDX_W-1:0] IDX_B   = IDX_W'(IDX);

    logic [PAGE_BITS-1:0] r_page;
    logic                 w_resident;
    logic                 w_match;
    logic                 w_shift;

    // Resident slot matching the reference; OR down the chain from below
    assign w_resident    = (IDX_OCC < i_occ);
    assign w_match       = w_resident && (r_page == i_query);
    assign o_match_below = w_match || i_match_below;

    // Shift on a hit if the hit is at or below this slot, else up to the bound
    assign w_shift = i_ctrl.load &&
                     (i_ctrl.hit_mode ? o_match_below : (IDX_B <= i_bound));

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_page <= i_prev_page;
        end
    end

    assign o_page = r_page;

endmodule

// ===== design/lru_stack_page_replacement_core.sv =====
// ----------------------------------------------------------------------------
// lru_stack_page_replacement_core
// LRU page stack as a chain of cells, most recent page on top, with a
// saturating replacement counter and a registered result.
//
//  channel     dir  handshake     payload
//  i_req       in   valid/ready   page, last_ref
//  o_rsp       out  valid/ready   hit, evicted_valid, evicted_page,
//                                 replacements, trace_done
//  i_cfg_we    in   write strobe  i_cfg_wdata = frames_in_use
//
//  One reference per cycle while the result register can take it: all cells
//  compare at once, the stack shifts at the accepting edge, and the result is in the next cycle.
//  The single result register bounds throughput: a new reference is taken
//  whenever it is empty or being drained in the same cycle.
//  Synchronous active-low reset empties the stack, clears the count and
//  sets the frame limit to 4. No clearing pass is needed.
//  A reference marked last_ref empties the stack and count after it.
// ----------------------------------------------------------------------------
`include "lru_stack_page_replacement_core_assert.svh"

module lru_stack_page_replacement_core #(
    parameter int unsigned MAX_FRAMES = 16,
    parameter int unsigned PAGE_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lrus_ref_if.sink                     i_req,
    lrus_res_if.source                   o_rsp,
    input  logic                         i_cfg_we,
    input  logic [lrus_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import lrus_pkg::*;

    localparam int unsigned OCC_W = $clog2(MAX_FRAMES + 1);
    localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned LIM_W = ((OCC_W > CFG_W) ? OCC_W : CFG_W) + 1;

    // Configuration and stack state
    logic [CFG_W-1:0]   r_frames;
    logic [OCC_W-1:0]   r_occ,   n_occ;
    logic [COUNT_W-1:0] r_count, n_count;

    // Result register
    logic                 r_out_valid;
    logic                 r_hit, r_ev_valid, r_done;
    logic [PAGE_BITS-1:0] r_ev_page;
    logic [COUNT_W-1:0]   r_out_count;

    logic                 w_accept;
    logic [LIM_W-1:0]     w_cfg_ext;
    logic [OCC_W-1:0]     w_limit;
    logic [IDX_W-1:0]     w_bottom;
    logic                 w_hit, w_cold, w_evict;
    logic [IDX_W-1:0]     w_bound;
    t_cell_ctrl           w_ctrl;

    logic [PAGE_BITS-1:0] w_page  [MAX_FRAMES+1];
    logic                 w_below [MAX_FRAMES+1];

    // Handshake: the result register frees up when drained
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;

    // Frame limit clamped to 1..MAX_FRAMES
    assign w_cfg_ext = LIM_W'(r_frames);
    always_comb begin
        priority if (w_cfg_ext == '0) begin
            w_limit = OCC_W'(1);
        end else if (w_cfg_ext > LIM_W'(MAX_FRAMES)) begin
            w_limit = OCC_W'(MAX_FRAMES);
        end else begin
            w_limit = OCC_W'(w_cfg_ext);
        end
    end
    assign w_bottom = IDX_W'(w_limit - OCC_W'(1));

    // Classify the reference
    assign w_hit   = w_below[0];
    assign w_cold  = !w_hit && (r_occ < w_limit);
    assign w_evict = !w_hit && !w_cold;
    assign w_bound = w_cold ? IDX_W'(r_occ) : w_bottom;

    assign w_ctrl.load     = w_accept;
    assign w_ctrl.hit_mode = w_hit;

    // Cell chain: slot 0 takes the reference, each slot feeds the next one
    assign w_page[0]           = i_req.page;
    assign w_below[MAX_FRAMES] = 1'b0;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        lrus_cell #(
            .IDX       (g),
            .PAGE_BITS (PAGE_BITS),
            .OCC_W     (OCC_W),
            .IDX_W     (IDX_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_query       (i_req.page),
            .i_prev_page   (w_page[g]),
            .i_bound       (w_bound),
            .i_occ         (r_occ),
            .i_match_below (w_below[g+1]),
            .o_match_below (w_below[g]),
            .o_page        (w_page[g+1])
        );
    end

    // Occupancy and saturating count
    always_comb begin
        n_occ   = r_occ;
        n_count = r_count;
        if (w_cold) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (w_evict) begin
            n_occ = w_limit;
            if (r_count != '1) begin
                n_count = r_count + COUNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames    <= FRAMES_RESET;
            r_occ       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frames <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
                if (i_req.last_ref) begin
                    r_occ   <= '0;
                    r_count <= '0;
                end else begin
                    r_occ   <= n_occ;
                    r_count <= n_count;
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the bottom slot's page sits at chain tap w_limit
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit       <= w_hit;
            r_ev_valid  <= w_evict;
            r_ev_page   <= w_evict ? w_page[w_limit] : '0;
            r_out_count <= n_count;
            r_done      <= i_req.last_ref;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.hit           = r_hit;
    assign o_rsp.evicted_valid = r_ev_valid;
    assign o_rsp.evicted_page  = r_ev_page;
    assign o_rsp.replacements  = r_out_count;
    assign o_rsp.trace_done    = r_done;

    // Checks
    `LRUS_ASSERT(a_occ_max, i_clk, i_rst_n, r_occ <= OCC_W'(MAX_FRAMES))
    `LRUS_ASSERT(a_hit_no_evict, i_clk, i_rst_n, r_out_valid |-> !(r_hit && r_ev_valid))
    `LRUS_ASSERT(a_evict_counted, i_clk, i_rst_n,
        (r_out_valid && r_ev_valid) |-> (r_out_count != '0))
    `LRUS_ASSERT(a_trace_clear, i_clk, i_rst_n,
        (w_accept && i_req.last_ref) |=> (r_occ == '0 && r_count == '0))

endmodule

// ===== tb/lru_stack_page_replacement_core_test.sv =====
// ----------------------------------------------------------------------------
// lru_stack_page_replacement_core_test
// Self-checking bench for the LRU page stack. A shadow LRU stack predicts
// hit, eviction, replacement count and trace end for every accepted page
// reference. Directed references cover the corner cases, then random traces
// run over a pool of pages under a series of frame limits. Both channels
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module lru_stack_page_replacement_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lrus_pkg::*;

    localparam int unsigned PAGE_BITS   = 16;
    localparam int unsigned MAX_FRAMES  = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned NUM_PHASES  = 12;

    // One result item as the block reports it
    typedef struct packed {
        logic                 hit;
        logic                 evicted_valid;
        logic [PAGE_BITS-1:0] evicted_page;
        logic [COUNT_W-1:0]   replacements;
        logic                 trace_done;
    } t_lru_outcome;

    // Shadow LRU stack and queue of outcomes still owed by the block
    class t_stack_tracker;
        logic [PAGE_BITS-1:0] stack_pages [MAX_FRAMES];
        int unsigned          occupancy;
        logic [COUNT_W-1:0]   replace_count;
        logic [CFG_W-1:0]     frames;
        t_lru_outcome         owed_outcomes [$];
        int unsigned          errors;

        function new();
            frames = FRAMES_RESET;
            errors = 0;
            clear_trace();
        endfunction

        function void clear_trace();
            foreach (stack_pages[i]) stack_pages[i] = '0;
            occupancy     = 0;
            replace_count = '0;
        endfunction

        function int unsigned effective_limit();
            if (frames == 0) return 1;
            if (frames > MAX_FRAMES) return MAX_FRAMES;
            return frames;
        endfunction

        function int unsigned outstanding();
            return owed_outcomes.size();
        endfunction

        // Shift entries [0, depth) down one slot, page goes on top
        function void push_to_top(logic [PAGE_BITS-1:0] page, int unsigned depth);
            int unsigned i;
            for (i = depth; i > 0; i--) begin
                if (i < MAX_FRAMES) stack_pages[i] = stack_pages[i-1];
            end
            stack_pages[0] = page;
        endfunction

        // Apply one accepted reference and record the outcome it must produce
        function void apply_reference(logic [PAGE_BITS-1:0] page, logic last_ref);
            t_lru_outcome outcome;
            int           pos;
            int unsigned  limit;
            int unsigned  i;
            outcome = '0;
            limit   = effective_limit();
            pos     = -1;
            for (i = 0; i < occupancy; i++) begin
                if (stack_pages[i] == page) begin
                    pos = i;
                    break;
                end
            end
            if (pos >= 0) begin
                outcome.hit = 1'b1;
                push_to_top(page, pos);
            end else if (occupancy < limit) begin
                // cold miss, not counted
                push_to_top(page, occupancy);
                occupancy++;
            end else begin
                // full: drop the page at the limit depth, anything below goes too
                outcome.evicted_valid = 1'b1;
                outcome.evicted_page  = stack_pages[limit-1];
                occupancy = limit;
                push_to_top(page, limit - 1);
                if (replace_count != '1) replace_count++;
            end
            outcome.replacements = replace_count;
            outcome.trace_done   = last_ref;
            owed_outcomes.push_back(outcome);
            if (last_ref) clear_trace();
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one result item against the oldest owed outcome
        function void match_outcome(t_lru_outcome got);
            t_lru_outcome want;
            if (owed_outcomes.size() == 0) begin
                $display("%0t: result item with none expected, actual %0h", $time, got);
                errors++;
                return;
            end
            want = owed_outcomes.pop_front();
            report_field("hit", want.hit, got.hit);
            report_field("evicted_valid", want.evicted_valid, got.evicted_valid);
            report_field("evicted_page", want.evicted_page, got.evicted_page);
            report_field("replacements", want.replacements, got.replacements);
            report_field("trace_done", want.trace_done, got.trace_done);
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    lrus_ref_if #(.PAGE_BITS(PAGE_BITS)) req_ch ();
    lrus_res_if #(.PAGE_BITS(PAGE_BITS)) res_ch ();

    lru_stack_page_replacement_core #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    t_stack_tracker tracker = new();

    int unsigned ref_idle_pct;
    int unsigned res_idle_pct;
    bit          hold_off_req;
    int unsigned cycles_run;

    always #4 i_clk = ~i_clk;

    // Gap length: mostly none, some short, a few long
    function automatic int unsigned pick_gap(int unsigned pct);
        if ($urandom_range(99, 0) >= pct) return 0;
        if ($urandom_range(9, 0) < 8) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Offer one reference and wait until it is taken
    task automatic send_ref(input logic [PAGE_BITS-1:0] page, input logic last_ref);
        int unsigned gap;
        gap = pick_gap(ref_idle_pct);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.page     <= page;
        req_ch.last_ref <= last_ref;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        tracker.apply_reference(page, last_ref);
    endtask

    // Write the frame limit once the block has drained
    task automatic write_frames(input logic [CFG_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        tracker.frames = value;
    endtask

    // Result side: check accepted items, drive ready with random stalls
    initial begin
        int unsigned stall_left;
        t_lru_outcome got;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.hit           = res_ch.hit;
                got.evicted_valid = res_ch.evicted_valid;
                got.evicted_page  = res_ch.evicted_page;
                got.replacements  = res_ch.replacements;
                got.trace_done    = res_ch.trace_done;
                tracker.match_outcome(got);
            end
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_off_req) begin
                // long hold-off so the block fills and stalls its input
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else begin
                stall_left = pick_gap(res_idle_pct);
                if (stall_left > 0) begin
                    stall_left--;
                    res_ch.ready <= 1'b0;
                end else begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("lru_stack_page_replacement_core regression: fail");
        $finish;
    end

    // Stimulus
    initial begin
        logic [CFG_W-1:0]     frame_plan [NUM_PHASES];
        logic [PAGE_BITS-1:0] pool [32];
        logic [PAGE_BITS-1:0] page;
        logic                 last_ref;
        int unsigned          n_items;
        int unsigned          trace_left;
        int unsigned          pool_size;
        int unsigned          ph;
        int unsigned          k;
        int unsigned          p;

        frame_plan = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd17, 5'd8,
                       5'd1, 5'd5, 5'd16, 5'd3, 5'd12, 5'd4};
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        req_ch.valid    = 1'b0;
        req_ch.page     = '0;
        req_ch.last_ref = 1'b0;
        ref_idle_pct    = 20;
        res_idle_pct    = 20;
        hold_off_req    = 1'b0;
        trace_left      = 0;
        pool_size       = 1;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill four frames with extreme pages, hits, evictions
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h5555, 1'b0);
        send_ref(16'hAAAA, 1'b0);
        send_ref(16'hAAAA, 1'b0);   // hit on top
        send_ref(16'h0000, 1'b0);   // hit at the bottom
        send_ref(16'h1234, 1'b0);   // first replacement
        send_ref(16'h5555, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0000, 1'b1);   // end of trace: report, then clear
        send_ref(16'h0000, 1'b0);   // page 0 in an empty stack must miss
        send_ref(16'h8001, 1'b0);
        // limit lowered to one frame with two pages resident
        write_frames(5'd1);
        send_ref(16'h8001, 1'b0);
        send_ref(16'h0000, 1'b0);   // below the limit but still resident
        send_ref(16'h7FFE, 1'b0);   // evicts, drops the rest
        send_ref(16'h7FFE, 1'b0);
        send_ref(16'h0001, 1'b0);
        send_ref(16'h0001, 1'b1);

        // Random traces under a series of frame limits
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            write_frames(frame_plan[ph]);
            case ($urandom_range(2, 0))
                0: ref_idle_pct = 0;
                1: ref_idle_pct = 15;
                default: ref_idle_pct = 40;
            endcase
            case ($urandom_range(2, 0))
                0: res_idle_pct = 0;
                1: res_idle_pct = 15;
                default: res_idle_pct = 40;
            endcase
            if (ph == 1) begin
                ref_idle_pct = 0;
                res_idle_pct = 0;
            end
            if (ph == 3) hold_off_req = 1'b1;
            n_items = $urandom_range(95, 75);
            for (k = 0; k < n_items; k++) begin
                if (trace_left == 0) begin
                    // new trace, pool sized around the frame limit
                    trace_left = $urandom_range(80, 1);
                    pool_size  = $urandom_range(tracker.effective_limit() * 3 / 2 + 2, 1);
                    if (pool_size > 32) pool_size = 32;
                    for (p = 0; p < pool_size; p++) pool[p] = $urandom_range(16'hFFFF, 0);
                end
                if ($urandom_range(9, 0) == 0) page = $urandom_range(16'hFFFF, 0);
                else page = pool[$urandom_range(pool_size - 1, 0)];
                // the forced trace end is never on a phase's last item, so the stack
                // mostly carries into the next frame limit
                last_ref = (trace_left == 1 && k + 1 < n_items) ||
                           ($urandom_range(149, 0) == 0);
                send_ref(page, last_ref);
                trace_left--;
                if (last_ref) trace_left = 0;
            end
        end

        // Drain
        req_ch.valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("lru_stack_page_replacement_core regression: pass");
        end else begin
            $display("lru_stack_page_replacement_core regression: fail");
        end
        $finish;
    end

endmodule
